// ===== hdl/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, types and codes for the priority voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int NUM_VOICES = 64;
  localparam int IDX_W      = $clog2(NUM_VOICES);
  localparam int CNT_W      = $clog2(NUM_VOICES + 1);
  localparam int PRIO_W     = 32;
  localparam int VOICE_W    = 6;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [PRIO_W-1:0]  prio_t;
  typedef logic [VOICE_W-1:0] voice_t;

  localparam prio_t PRIO_CEIL = {PRIO_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_SETPRIO = 2'd2,
    REQ_RSVD    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  // Outcome of one pass over the voice pool
  typedef struct packed {
    logic  found_free;
    idx_t  free_idx;
    logic  victim_vld;
    idx_t  victim_idx;
    prio_t low_prio;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== hdl/pva_ram.sv =====
// ----------------------------------------------------------------------------
// pva_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pva_scan.sv =====
// ----------------------------------------------------------------------------
// pva_scan
// Walks the voice pool one entry a cycle through the priority RAM, looking
// for the first free voice and the lowest-priority active voice.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_scan (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [pva_pkg::NUM_VOICES-1:0]  active,
  input  wire pva_pkg::prio_t                  rd_data,
  output logic                                 rd_en,
  output pva_pkg::idx_t                        rd_addr,
  output logic                                 done,
  output pva_pkg::scan_res_t                   res
);

  logic              run_r, run_nxt;
  pva_pkg::cnt_t     cnt_r, cnt_nxt;
  logic              chk_v_r, chk_v_nxt;
  pva_pkg::idx_t     chk_idx_r, chk_idx_nxt;
  pva_pkg::scan_res_t res_r, res_nxt;
  logic              issue;
  logic              act;

  assign issue   = run_r && !res_r.found_free &&
                   (cnt_r < pva_pkg::cnt_t'(pva_pkg::NUM_VOICES));
  assign rd_en   = issue;
  assign rd_addr = cnt_r[pva_pkg::IDX_W-1:0];
  assign act     = active[chk_idx_r];
  assign done    = run_r && (res_r.found_free ||
                   (cnt_r == pva_pkg::cnt_t'(pva_pkg::NUM_VOICES) && !chk_v_r));
  assign res     = res_r;

  always_comb begin
    run_nxt     = run_r;
    cnt_nxt     = cnt_r;
    chk_v_nxt   = issue;
    chk_idx_nxt = rd_addr;
    res_nxt     = res_r;
    if (start) begin
      run_nxt            = 1'b1;
      cnt_nxt            = '0;
      chk_v_nxt          = 1'b0;
      res_nxt.found_free = 1'b0;
      res_nxt.victim_vld = 1'b0;
      res_nxt.low_prio   = pva_pkg::PRIO_CEIL;
    end else if (run_r) begin
      if (issue) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      // compare the entry whose priority just came out of the RAM
      if (chk_v_r && !res_r.found_free) begin
        if (!act) begin
          res_nxt.found_free = 1'b1;
          res_nxt.free_idx   = chk_idx_r;
        end else if (rd_data < res_r.low_prio) begin
          res_nxt.victim_vld = 1'b1;
          res_nxt.victim_idx = chk_idx_r;
          res_nxt.low_prio   = rd_data;
        end
      end
      if (done) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      cnt_r   <= '0;
      chk_v_r <= 1'b0;
      res_r   <= '{found_free: 1'b0, free_idx: '0, victim_vld: 1'b0,
                   victim_idx: '0, low_prio: pva_pkg::PRIO_CEIL};
    end else begin
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      chk_v_r <= chk_v_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/priority_voice_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// priority_voice_allocator_unit
// Voice pool allocator: acquire with priority-based stealing, free, and
// set-priority requests over a pool of mixer voices.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ channel (valid/stall); one result per request
//   leaves on the out_ channel (valid/stall), held in an output register.
//   Acquire walks the priority RAM once, one voice per cycle, with a
//   single 32-bit comparator, and stops early when a free voice turns up.
//   Free, set-priority and unknown requests skip the scan and go straight
//   to the response state. One request is in flight at a time: in_stall is
//   high from acceptance until its result is loaded into the output register.
//   A new request is accepted while the previous result still waits there.
//   When the receiver stalls, the result holds; a following request finishes
//   its scan and then waits until the output register frees up.
//   Reset clears all active and drop-handler marks and the handshakes; the
//   priority RAM needs no clearing since a priority is read only for an
//   active voice, whose priority was written when it was acquired.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_voice_allocator_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_req_type,
  input  wire logic [31:0]             in_req_priority,
  input  wire logic [5:0]              in_target_voice,
  input  wire logic                    in_has_drop_handler,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_granted,
  output logic [5:0]                   out_granted_voice,
  output logic                         out_was_stolen,
  output logic                         out_notify_dropped
);

  pva_pkg::state_t    state_r, state_nxt;
  pva_pkg::req_type_t type_r;
  pva_pkg::prio_t     prio_r;
  pva_pkg::voice_t    tgt_r;
  logic               hdl_r;
  logic [pva_pkg::NUM_VOICES-1:0] active_r, active_nxt;
  logic [pva_pkg::NUM_VOICES-1:0] handler_r, handler_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               grant_r, grant_nxt;
  pva_pkg::voice_t    voice_r, voice_nxt;
  logic               stolen_r, stolen_nxt;
  logic               notify_r, notify_nxt;

  logic               accept;
  logic               scan_start;
  logic               scan_done;
  pva_pkg::scan_res_t scan_res;
  logic               rd_en;
  pva_pkg::idx_t      rd_addr;
  pva_pkg::prio_t     rd_data;
  logic               wr_en;
  pva_pkg::idx_t      wr_addr;
  logic               fire;
  logic               tgt_ok;
  pva_pkg::idx_t      tgt_idx;
  pva_pkg::idx_t      slot;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != pva_pkg::ST_IDLE) || !rst_n;
  assign scan_start = accept && (pva_pkg::req_type_t'(in_req_type) == pva_pkg::REQ_ACQUIRE);
  assign fire       = (state_r == pva_pkg::ST_RESP) && (!out_valid_r || !out_stall);
  assign tgt_ok     = 32'(tgt_r) < 32'(pva_pkg::NUM_VOICES);
  assign tgt_idx    = pva_pkg::idx_t'(tgt_r);

  pva_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .active  (active_r),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .done    (scan_done),
    .res     (scan_res)
  );

  pva_ram #(
    .WIDTH (pva_pkg::PRIO_W),
    .DEPTH (pva_pkg::NUM_VOICES)
  ) u_prio_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (prio_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    handler_nxt   = handler_r;
    out_valid_nxt = out_valid_r && out_stall;
    grant_nxt     = grant_r;
    voice_nxt     = voice_r;
    stolen_nxt    = stolen_r;
    notify_nxt    = notify_r;
    wr_en         = 1'b0;
    wr_addr       = tgt_idx;
    slot          = scan_res.free_idx;

    case (state_r)
      pva_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = scan_start ? pva_pkg::ST_SCAN : pva_pkg::ST_RESP;
        end
      end
      pva_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = pva_pkg::ST_RESP;
        end
      end
      pva_pkg::ST_RESP: begin
        if (fire) begin
          state_nxt     = pva_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          grant_nxt     = 1'b1;
          voice_nxt     = '0;
          stolen_nxt    = 1'b0;
          notify_nxt    = 1'b0;
          case (type_r)
            pva_pkg::REQ_ACQUIRE: begin
              if (scan_res.found_free) begin
                slot = scan_res.free_idx;
              end else begin
                slot       = scan_res.victim_idx;
                grant_nxt  = scan_res.victim_vld && (scan_res.low_prio < prio_r);
                stolen_nxt = grant_nxt;
                notify_nxt = grant_nxt && handler_r[scan_res.victim_idx];
              end
              if (grant_nxt) begin
                voice_nxt         = pva_pkg::voice_t'(slot);
                active_nxt[slot]  = 1'b1;
                handler_nxt[slot] = hdl_r;
                wr_en             = 1'b1;
                wr_addr           = slot;
              end
            end
            pva_pkg::REQ_FREE: begin
              if (tgt_ok) begin
                active_nxt[tgt_idx] = 1'b0;
              end
            end
            pva_pkg::REQ_SETPRIO: begin
              wr_en = tgt_ok;
            end
            default: begin
              grant_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = pva_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pva_pkg::ST_IDLE;
      active_r    <= '0;
      handler_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      handler_r   <= handler_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the request fields for the duration of the operation
  always_ff @(posedge clk) begin
    if (accept) begin
      type_r <= pva_pkg::req_type_t'(in_req_type);
      prio_r <= in_req_priority;
      tgt_r  <= in_target_voice;
      hdl_r  <= in_has_drop_handler;
    end
    grant_r  <= grant_nxt;
    voice_r  <= voice_nxt;
    stolen_r <= stolen_nxt;
    notify_r <= notify_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = grant_r;
  assign out_granted_voice  = voice_r;
  assign out_was_stolen     = stolen_r;
  assign out_notify_dropped = notify_r;

endmodule

`default_nettype wire

// ===== hdl/pva_chk.sv =====
// ----------------------------------------------------------------------------
// pva_chk
// Port-level checks for the priority voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_granted,
  input wire logic [5:0]  out_granted_voice,
  input wire logic        out_was_stolen,
  input wire logic        out_notify_dropped
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted) &&
    $stable(out_granted_voice) && $stable(out_was_stolen) && $stable(out_notify_dropped))
    else $error("stalled result changed");

  // one request in flight: stall the input right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while busy");

  // a result without a grant reports nothing else
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_granted_voice == 6'd0 &&
    !out_was_stolen && !out_notify_dropped)
    else $error("failed request carries voice data");

  // a drop notice only comes with a successful steal
  a_notify_steal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notify_dropped |-> out_was_stolen && out_granted)
    else $error("drop notice without steal");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind priority_voice_allocator_unit pva_chk u_pva_chk (.*);

`default_nettype wire
